>>> src/spectrum_db_base64_encoder_defines.svh
// assertion macros shared by the spectrum dB base64 encoder rtl
`ifndef SPECTRUM_DB_BASE64_ENCODER_DEFINES_SVH
`define SPECTRUM_DB_BASE64_ENCODER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SDB64_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define SDB64_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/sdb64_pkg.sv
// shared types, constants and the base64 alphabet for the spectrum dB encoder
`timescale 1ns / 1ps
`default_nettype none

package sdb64_pkg;

    // register indexes on the configuration port
    localparam logic [1:0] REG_ACCUM = 2'd0;
    localparam logic [1:0] REG_LEN   = 2'd1;

    // output code ceiling, also used for skipped bins and zero power
    localparam logic [23:0] CODE_MAX = 24'd16700000;

    // low 32 bits of 10*log10(2)*1e5 in q.16; the upper part is exactly 4 * 2^32
    localparam logic [31:0] KQ_LO = 32'd2548432612;

    // (3830000 << 16) + 64 * kq, the constant the scaled log is taken from
    localparam logic [43:0] C0 = 44'd1513614194944;

    // (64 - 16) << 24: bias plus the removal of the 16 fraction bits of power
    localparam logic [31:0] LR_BIAS_Q24 = 32'h3000_0000;

    // rounds of mantissa squaring, one fraction bit each
    localparam int unsigned FRAC_W = 24;

    // normalizer result: leading one position and the top 32 bits, leading one included
    typedef struct packed {
        logic        done;
        logic [5:0]  exp;
        logic [31:0] mant;
    } t_norm_res;

    // base64 character of a six bit value
    function automatic logic [7:0] b64_char(input logic [5:0] idx);
        logic [7:0] ch;
        if (idx < 6'd26) begin
            ch = 8'd65 + {2'b00, idx};          // 'A'
        end else if (idx < 6'd52) begin
            ch = 8'd71 + {2'b00, idx};          // 'a' - 26
        end else if (idx < 6'd62) begin
            ch = {2'b00, idx} - 8'd4;           // '0' - 52
        end else if (idx == 6'd62) begin
            ch = 8'd43;                         // '+'
        end else begin
            ch = 8'd47;                         // '/'
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> src/sdb64_mul.sv
// shared 32x32 unsigned multiplier with a registered product
`timescale 1ns / 1ps
`default_nettype none

module sdb64_mul (
    input  wire logic        i_clk,
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    output logic      [63:0] o_prod
);

    logic [63:0] r_prod;

    // one product per cycle, available the cycle after the operands
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

>>> src/sdb64_norm.sv
// iterative leading-one normalizer: six halving steps over a 64 bit word
`timescale 1ns / 1ps
`default_nettype none

module sdb64_norm (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire logic [63:0]          i_value,
    output sdb64_pkg::t_norm_res      o_res
);

    logic [63:0] r_x;
    logic [5:0]  r_e;
    logic [2:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [5:0]  shamt;
    logic [63:0] hi_mask;
    logic        hi_zero;

    // shift of this step: 32, 16, 8, 4, 2, 1
    assign shamt   = 6'd32 >> r_step;
    assign hi_mask = ~(64'hFFFF_FFFF_FFFF_FFFF >> shamt);
    assign hi_zero = (r_x & hi_mask) == 64'd0;

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_step <= 3'd0;
        end else if (r_busy) begin
            r_step <= r_step + 3'd1;
            if (r_step == 3'd5) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // shift the word up while its top bits are zero
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_value;
            r_e <= 6'd63;
        end else if (r_busy && hi_zero) begin
            r_x <= r_x << shamt;
            r_e <= r_e - shamt;
        end
    end

    assign o_res.done = r_done;
    assign o_res.exp  = r_e;
    assign o_res.mant = r_x[63:32];

endmodule

`default_nettype wire

>>> src/spectrum_db_base64_encoder.sv
// top level: bin counter, log2 sequencer, dB scaling and base64 output register
`timescale 1ns / 1ps
`default_nettype none

`include "spectrum_db_base64_encoder_defines.svh"

// Power spectrum to dB encoder. Each input beat carries one accumulated power
// sample (48 bits, 16 fraction bits); each output beat carries code = -dB*1e5
// clamped to 0..16700000, its four base64 characters (top six bits first) and
// an end-of-spectrum flag. dB is 10*log10(power/(2*accums*length)) - 38.3, and
// the first SKIPPED_BINS bins of a spectrum, as well as zero power, give the
// ceiling code. Between accepted input beats a normal bin goes through two
// base-2 logarithms, each a leading-one normalize (six halving steps, then
// the result is picked up) plus 24 squaring rounds on the one shared 32x32
// multiplier, then the scaling states KQI and KQF on that same multiplier,
// SUM, ADD and FIN, a hand-off in DONE and a return to idle. Skipped bins
// and zero power go straight to DONE. The finished result sits in an output
// register, so the next input beat is taken while it waits. Write the two
// configuration registers only while no beat is in flight.
module spectrum_db_base64_encoder #(
    parameter int MAX_BINS     = 65536,
    parameter int SKIPPED_BINS = 10
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_wr_data,
    // input beats
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [47:0] i_power,
    // output beats
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic      [23:0] o_code,
    output logic      [7:0]  o_char_first,
    output logic      [7:0]  o_char_second,
    output logic      [7:0]  o_char_third,
    output logic      [7:0]  o_char_fourth,
    output logic             o_end_of_spectrum
);

    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int LEN_W = BIN_W + 1;
    localparam int DEN_W = 24 + LEN_W + 1;
    localparam int SUB_W = 44;
    localparam int FRAC_W_L = sdb64_pkg::FRAC_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_NORM = 4'd1;
    localparam logic [3:0] S_SQR  = 4'd2;
    localparam logic [3:0] S_KQI  = 4'd3;
    localparam logic [3:0] S_KQF  = 4'd4;
    localparam logic [3:0] S_SUM  = 4'd5;
    localparam logic [3:0] S_ADD  = 4'd6;
    localparam logic [3:0] S_FIN  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // control registers
    logic [3:0]       r_state, n_state;
    logic             r_phase, n_phase;
    logic [4:0]       r_round, n_round;
    logic [BIN_W-1:0] r_bin,   n_bin;
    logic             r_out_valid, n_out_valid;
    logic [23:0]      r_acc;
    logic [16:0]      r_len;

    // datapath registers
    logic [FRAC_W_L-1:0] r_frac, n_frac;
    logic [29:0]      r_l2p,   n_l2p;
    logic [31:0]      r_lr,    n_lr;
    logic [DEN_W-1:0] r_den,   n_den;
    logic [SUB_W-1:0] r_sub,   n_sub;
    logic [34:0]      r_fterm, n_fterm;
    logic [23:0]      r_code,  n_code;
    logic             r_eos,   n_eos;
    logic [23:0]      r_out_code;
    logic             r_out_eos;

    // shared unit hookup
    logic [31:0]           mul_a;
    logic [31:0]           mul_b;
    logic [63:0]           r_prod;
    logic                  norm_start;
    logic [63:0]           norm_value;
    sdb64_pkg::t_norm_res  norm_res;

    // effective configuration and per-beat decode
    logic [23:0]      acc_eff;
    logic [31:0]      len_wide;
    logic [LEN_W-1:0] len_eff;
    logic             eos;
    logic             skip;
    logic             in_acc;
    logic             out_acc;
    logic             out_load;

    // squaring round and scaling terms
    logic [32:0]      sq_t;
    logic             sq_bit;
    logic [31:0]      sq_m;
    logic [23:0]      frac_new;
    logic [58:0]      fsum;
    logic [SUB_W-1:0] fin_diff;
    logic [24:0]      fin_q;

    sdb64_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (r_prod)
    );

    sdb64_norm u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (norm_start),
        .i_value (norm_value),
        .o_res   (norm_res)
    );

    // handshakes
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_acc    = r_out_valid && !i_out_stall;
    assign o_in_stall = r_state != S_IDLE;

    // zero count means one, length limited to 1..MAX_BINS
    assign acc_eff  = (r_acc == 24'd0) ? 24'd1 : r_acc;
    assign len_wide = 32'(r_len);
    assign len_eff  = (len_wide == 32'd0) ? LEN_W'(1) :
                      (len_wide > 32'(MAX_BINS)) ? LEN_W'(MAX_BINS) : LEN_W'(len_wide);
    assign eos      = ({1'b0, r_bin} + LEN_W'(1)) >= len_eff;
    assign skip     = 32'(r_bin) < 32'(SKIPPED_BINS);

    // one squaring round: renormalize the q1.31 square and pull out a bit
    assign sq_t     = r_prod[63:31];
    assign sq_bit   = sq_t[32];
    assign sq_m     = sq_bit ? sq_t[32:1] : sq_t[31:0];
    assign frac_new = {r_frac[FRAC_W_L-2:0], sq_bit};

    // kq * frac = kq_lo * frac + frac << 34, then drop 24 fraction bits
    assign fsum     = 59'(r_prod) + (59'(r_lr[23:0]) << 34);
    assign fin_diff = sdb64_pkg::C0 - r_sub;
    assign fin_q    = fin_diff[40:16];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_round     = r_round;
        n_bin       = r_bin;
        n_frac      = r_frac;
        n_l2p       = r_l2p;
        n_lr        = r_lr;
        n_den       = r_den;
        n_sub       = r_sub;
        n_fterm     = r_fterm;
        n_code      = r_code;
        n_eos       = r_eos;
        mul_a       = 32'(acc_eff);
        mul_b       = 32'(len_eff);
        norm_start  = 1'b0;
        norm_value  = 64'(r_den);
        out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_eos = eos;
                    n_bin = eos ? '0 : r_bin + BIN_W'(1);
                    if (skip || i_power == 48'd0) begin
                        n_code  = sdb64_pkg::CODE_MAX;
                        n_state = S_DONE;
                    end else begin
                        norm_start = 1'b1;
                        norm_value = 64'(i_power);
                        n_phase    = 1'b0;
                        n_state    = S_NORM;
                    end
                end
            end
            S_NORM: begin
                // the multiplier forms accums * length while power normalizes
                if (!r_phase) begin
                    n_den = {r_prod[DEN_W-2:0], 1'b0};
                end
                if (norm_res.done) begin
                    mul_a   = norm_res.mant;
                    mul_b   = norm_res.mant;
                    n_round = 5'd0;
                    n_state = S_SQR;
                end
            end
            S_SQR: begin
                mul_a   = sq_m;
                mul_b   = sq_m;
                n_frac  = frac_new;
                n_round = r_round + 5'd1;
                if (r_round == 5'(FRAC_W_L - 1)) begin
                    if (!r_phase) begin
                        n_l2p      = {norm_res.exp, frac_new};
                        norm_start = 1'b1;
                        norm_value = 64'(r_den);
                        n_phase    = 1'b1;
                        n_state    = S_NORM;
                    end else begin
                        n_lr    = 32'(r_l2p) + sdb64_pkg::LR_BIAS_Q24
                                  - 32'({norm_res.exp, frac_new});
                        n_state = S_KQI;
                    end
                end
            end
            S_KQI: begin
                mul_a   = sdb64_pkg::KQ_LO;
                mul_b   = 32'(r_lr[31:24]);
                n_state = S_KQF;
            end
            S_KQF: begin
                // kq * int = kq_lo * int + int << 34
                n_sub   = SUB_W'(r_prod) + (SUB_W'(r_lr[31:24]) << 34);
                mul_a   = sdb64_pkg::KQ_LO;
                mul_b   = 32'(r_lr[23:0]);
                n_state = S_SUM;
            end
            S_SUM: begin
                n_fterm = fsum[58:24];
                n_state = S_ADD;
            end
            S_ADD: begin
                n_sub   = r_sub + SUB_W'(r_fterm);
                n_state = S_FIN;
            end
            S_FIN: begin
                // negative result clamps to zero, large ones to the ceiling
                if (r_sub > sdb64_pkg::C0) begin
                    n_code = 24'd0;
                end else if (fin_q > 25'(sdb64_pkg::CODE_MAX)) begin
                    n_code = sdb64_pkg::CODE_MAX;
                end else begin
                    n_code = fin_q[23:0];
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = out_load ? 1'b1 : (out_acc ? 1'b0 : r_out_valid);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= 1'b0;
            r_round     <= 5'd0;
            r_bin       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_round     <= n_round;
            r_bin       <= n_bin;
            r_out_valid <= n_out_valid;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 24'd1;
            r_len <= 17'd32768;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sdb64_pkg::REG_ACCUM: r_acc <= i_cfg_wr_data;
                sdb64_pkg::REG_LEN:   r_len <= i_cfg_wr_data[16:0];
                default: begin
                end
            endcase
        end
    end

    // datapath and output register
    always_ff @(posedge i_clk) begin
        r_frac  <= n_frac;
        r_l2p   <= n_l2p;
        r_lr    <= n_lr;
        r_den   <= n_den;
        r_sub   <= n_sub;
        r_fterm <= n_fterm;
        r_code  <= n_code;
        r_eos   <= n_eos;
        if (out_load) begin
            r_out_code <= r_code;
            r_out_eos  <= r_eos;
        end
    end

    // output beat
    assign o_out_valid       = r_out_valid;
    assign o_code            = r_out_code;
    assign o_end_of_spectrum = r_out_eos;
    assign o_char_first      = sdb64_pkg::b64_char(r_out_code[23:18]);
    assign o_char_second     = sdb64_pkg::b64_char(r_out_code[17:12]);
    assign o_char_third      = sdb64_pkg::b64_char(r_out_code[11:6]);
    assign o_char_fourth     = sdb64_pkg::b64_char(r_out_code[5:0]);

    // checks
    `SDB64_ASSERT_NEXT(a_busy_after_accept, in_acc, o_in_stall, "input taken while busy")
    `SDB64_ASSERT_NOW(a_norm_done_in_norm, norm_res.done, r_state == S_NORM, "stray normalize")
    `SDB64_ASSERT_NOW(a_code_range, r_out_valid, r_out_code <= sdb64_pkg::CODE_MAX, "code range")
    `SDB64_ASSERT_NOW(a_load_from_done, $rose(r_out_valid), $past(r_state) == S_DONE, "bad load")

endmodule

`default_nettype wire
